// ===== hdl/kce_pkg.sv =====
// Shared constants for the k-means cluster engine: field widths, memory
// geometry and request codes. No dependencies.
`default_nettype none

package kce_pkg;

    // Store geometry
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 16;
    localparam int PT_BITS      = $clog2(MAX_POINTS);
    localparam int DIM_BITS     = $clog2(MAX_DIMS);
    localparam int CL_BITS      = $clog2(MAX_CLUSTERS);
    localparam int PT_DEPTH     = MAX_POINTS * MAX_DIMS;
    localparam int CEN_DEPTH    = MAX_CLUSTERS * MAX_DIMS;

    // Arithmetic widths
    localparam int VAL_BITS  = 16;
    localparam int SUM_BITS  = 26;
    localparam int CNT_BITS  = 11;
    localparam int SQ_BITS   = 34;
    localparam int DIST_BITS = 36;
    localparam int INR_BITS  = 48;

    // Request codes
    localparam logic [2:0] OP_LOAD_PT  = 3'd0;
    localparam logic [2:0] OP_LOAD_CEN = 3'd1;
    localparam logic [2:0] OP_RUN      = 3'd2;
    localparam logic [2:0] OP_RD_LBL   = 3'd3;
    localparam logic [2:0] OP_RD_CEN   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLUSTERS = 2'd0;
    localparam logic [1:0] CFG_ITERS    = 2'd1;
    localparam logic [1:0] CFG_DIMS     = 2'd2;
    localparam logic [1:0] CFG_POINTS   = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/kce_div.sv =====
// Iterative signed-by-unsigned divider for the centroid update, truncating
// toward zero, one quotient bit per cycle. Depends on kce_pkg.
`default_nettype none

module kce_div import kce_pkg::*; (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire  signed [SUM_BITS-1:0] dividend,
    input  wire  [CNT_BITS-1:0]       divisor,
    output logic                      done,
    output logic signed [VAL_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(SUM_BITS);

    logic [SUM_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  dvs_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg;
    logic                 neg_reg;
    logic                 done_reg;
    logic [CNT_BITS:0]    rem_sh;
    logic [CNT_BITS:0]    rem_sub;
    logic                 fits;

    // One restoring step
    assign rem_sh  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
                neg_reg  <= dividend[SUM_BITS-1];
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg  <= {quo_reg[SUM_BITS-2:0], fits};
                rem_reg  <= fits ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(SUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg[VAL_BITS-1:0] + 1'b1) : quo_reg[VAL_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/kmeans_cluster_engine_top.sv =====
// Lloyd k-means engine: point, centroid, label and sum memories walked by a
// sequencer. A read result passes through rd_pend_reg into the output register;
// no new request is taken while a read is pending or a result is held. A run
// does per iteration the assignment pass, the divider update of the centroids
// and the iteration check, then an inertia pass and the result.
// After reset the label memory is cleared entry by entry; no request is
// taken meanwhile. Reset is synchronous, active low.
`default_nettype none

module kmeans_cluster_engine_top import kce_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // item_index[9:0], coord_index[12:10], coord_value[28:13]
    input  wire  [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // label[3:0], centroid_value[19:4], inertia[67:20],
                                   // iterations_used[75:68], converged[76]
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [10:0] cfg_wdata
);

    // Sequencer states
    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_ASN      = 5'd2;
    localparam logic [4:0] S_ASN_DRN  = 5'd3;
    localparam logic [4:0] S_ASN_LBL  = 5'd4;
    localparam logic [4:0] S_ACC      = 5'd5;
    localparam logic [4:0] S_ACC_FIN  = 5'd6;
    localparam logic [4:0] S_UPD      = 5'd7;
    localparam logic [4:0] S_UPD_RD   = 5'd8;
    localparam logic [4:0] S_UPD_DIV  = 5'd9;
    localparam logic [4:0] S_UPD_WAIT = 5'd10;
    localparam logic [4:0] S_ITER     = 5'd11;
    localparam logic [4:0] S_INR_LBL  = 5'd12;
    localparam logic [4:0] S_INR_GET  = 5'd13;
    localparam logic [4:0] S_INR      = 5'd14;
    localparam logic [4:0] S_INR_DRN  = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    // Input fields
    logic [2:0]          in_op;
    logic [PT_BITS-1:0]  in_item;
    logic [DIM_BITS-1:0] in_coord;
    logic [VAL_BITS-1:0] in_val;
    logic                accept;

    assign in_op    = s_tuser;
    assign in_item  = s_tdata[9:0];
    assign in_coord = s_tdata[12:10];
    assign in_val   = s_tdata[28:13];

    // Configuration
    logic [4:0]  cfg_k_reg;
    logic [7:0]  cfg_lim_reg;
    logic [3:0]  cfg_dims_reg;
    logic [10:0] cfg_pts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_k_reg    <= 5'd4;
            cfg_lim_reg  <= 8'd100;
            cfg_dims_reg <= 4'd2;
            cfg_pts_reg  <= 11'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CLUSTERS: cfg_k_reg    <= cfg_wdata[4:0];
                CFG_ITERS:    cfg_lim_reg  <= cfg_wdata[7:0];
                CFG_DIMS:     cfg_dims_reg <= cfg_wdata[3:0];
                CFG_POINTS:   cfg_pts_reg  <= cfg_wdata;
                default:      cfg_pts_reg  <= cfg_pts_reg;
            endcase
        end
    end

    // Effective run limits
    logic [10:0] n_eff;
    logic [4:0]  cl_eff;
    logic [4:0]  k_eff;
    logic [3:0]  dims_eff;
    logic [7:0]  lim_eff;

    always_comb begin
        n_eff    = (cfg_pts_reg > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : cfg_pts_reg;
        cl_eff   = (cfg_k_reg == 5'd0) ? 5'd1 :
                   (cfg_k_reg > 5'(MAX_CLUSTERS)) ? 5'(MAX_CLUSTERS) : cfg_k_reg;
        k_eff    = ({6'd0, cl_eff} > n_eff) ? n_eff[4:0] : cl_eff;
        dims_eff = (cfg_dims_reg == 4'd0) ? 4'd1 :
                   (cfg_dims_reg > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : cfg_dims_reg;
        lim_eff  = (cfg_lim_reg == 8'd0) ? 8'd1 : cfg_lim_reg;
    end

    // Sequencer registers
    logic [4:0]           state_reg;
    logic [PT_BITS-1:0]   clr_reg;
    logic [PT_BITS-1:0]   pi_reg;
    logic [CL_BITS-1:0]   cj_reg;
    logic [DIM_BITS-1:0]  cd_reg;
    logic [PT_BITS-1:0]   nm1_reg;
    logic [CL_BITS-1:0]   km1_reg;
    logic [DIM_BITS-1:0]  dm1_reg;
    logic [7:0]           limit_reg;
    logic [7:0]           iters_reg;
    logic                 changed_reg;
    logic                 first_reg;
    logic                 conv_reg;
    logic [CL_BITS-1:0]   best_reg;
    logic [DIST_BITS-1:0] bestd_reg;
    logic [DIST_BITS-1:0] acc_reg;
    logic [INR_BITS-1:0]  inertia_reg;
    logic [CNT_BITS-1:0]  cnt_reg [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] touched_reg;
    logic                 rd_pend_reg;
    logic                 rd_lbl_reg;
    logic                 rd_ok_reg;
    logic                 m_tvalid_reg;
    logic [79:0]          m_tdata_reg;

    // Distance pipeline tags
    logic                 p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic                 p1_last_reg, p2_last_reg, p3_last_reg;
    logic                 p1_inr_reg, p2_inr_reg, p3_inr_reg;
    logic [CL_BITS-1:0]   p1_j_reg, p2_j_reg, p3_j_reg;
    logic signed [VAL_BITS:0] diff_reg;
    logic signed [SQ_BITS-1:0] sq_full;
    logic [SQ_BITS-1:0]   sq_reg;

    // Sum accumulate write tag
    logic                       acc_we_reg;
    logic [CL_BITS+DIM_BITS-1:0] acc_waddr_reg;

    // Memories
    logic [VAL_BITS-1:0] pt_mem  [PT_DEPTH];
    logic [VAL_BITS-1:0] cen_mem [CEN_DEPTH];
    logic [CL_BITS-1:0]  lbl_mem [MAX_POINTS];
    logic [SUM_BITS-1:0] sum_mem [CEN_DEPTH];
    logic [VAL_BITS-1:0] pt_rdata_reg;
    logic [VAL_BITS-1:0] cen_rdata_reg;
    logic [CL_BITS-1:0]  lbl_rdata_reg;
    logic [SUM_BITS-1:0] sum_rdata_reg;

    logic                        idle;
    logic                        pt_we, cen_we, lbl_we;
    logic [PT_BITS+DIM_BITS-1:0] pt_addr;
    logic [CL_BITS+DIM_BITS-1:0] cen_raddr, cen_waddr, sum_raddr;
    logic [VAL_BITS-1:0]         cen_wdata;
    logic [PT_BITS-1:0]          lbl_raddr, lbl_waddr;
    logic [CL_BITS-1:0]          lbl_wdata;
    logic [SUM_BITS-1:0]         sum_wdata;
    logic                        div_done;
    logic signed [VAL_BITS-1:0]  div_quo;
    logic [DIST_BITS-1:0]        dist_sum;
    logic                        pipe_busy;
    logic [CL_BITS-1:0]          old_lbl;
    logic [7:0]                  iters_next;

    assign idle     = (state_reg == S_IDLE);
    assign s_tready = idle && !rd_pend_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Address and write selection
    always_comb begin
        pt_addr   = {pi_reg, cd_reg};
        pt_we     = accept && (in_op == OP_LOAD_PT);
        cen_raddr = idle ? {in_item[CL_BITS-1:0], in_coord} : {cj_reg, cd_reg};
        cen_we    = (accept && (in_op == OP_LOAD_CEN) && (in_item < PT_BITS'(MAX_CLUSTERS)))
                    || ((state_reg == S_UPD_WAIT) && div_done);
        cen_waddr = idle ? {in_item[CL_BITS-1:0], in_coord} : {cj_reg, cd_reg};
        cen_wdata = idle ? in_val : div_quo;
        lbl_raddr = idle ? in_item : pi_reg;
        lbl_we    = (state_reg == S_CLR) || (state_reg == S_ASN_LBL);
        lbl_waddr = (state_reg == S_CLR) ? clr_reg : pi_reg;
        lbl_wdata = (state_reg == S_CLR) ? '0 : best_reg;
        sum_raddr = (state_reg == S_ACC) ? {best_reg, cd_reg} : {cj_reg, cd_reg};
        sum_wdata = (touched_reg[best_reg] ? sum_rdata_reg : '0)
                    + {{(SUM_BITS-VAL_BITS){pt_rdata_reg[VAL_BITS-1]}}, pt_rdata_reg};
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[{in_item, in_coord}] <= in_val;
        end
        pt_rdata_reg <= pt_mem[pt_addr];
    end

    always_ff @(posedge aclk) begin
        if (cen_we) begin
            cen_mem[cen_waddr] <= cen_wdata;
        end
        cen_rdata_reg <= cen_mem[cen_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lbl_we) begin
            lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        lbl_rdata_reg <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we_reg) begin
            sum_mem[acc_waddr_reg] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    // Centroid mean divider
    kce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_UPD_DIV),
        .dividend (sum_rdata_reg),
        .divisor  (cnt_reg[cj_reg]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign dist_sum   = acc_reg + {{(DIST_BITS-SQ_BITS){1'b0}}, sq_reg};
    assign pipe_busy  = p1_vld_reg || p2_vld_reg || p3_vld_reg;
    assign old_lbl    = first_reg ? '0 : lbl_rdata_reg;
    assign iters_next = iters_reg + 1'b1;
    // Full-width square of the coordinate difference
    assign sq_full    = diff_reg * diff_reg;

    // Distance pipeline: difference, square, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= (state_reg == S_ASN) || (state_reg == S_INR);
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
        p1_last_reg <= (cd_reg == dm1_reg);
        p1_inr_reg  <= (state_reg == S_INR);
        p1_j_reg    <= cj_reg;
        p2_last_reg <= p1_last_reg;
        p2_inr_reg  <= p1_inr_reg;
        p2_j_reg    <= p1_j_reg;
        p3_last_reg <= p2_last_reg;
        p3_inr_reg  <= p2_inr_reg;
        p3_j_reg    <= p2_j_reg;
        diff_reg    <= $signed({pt_rdata_reg[VAL_BITS-1], pt_rdata_reg})
                       - $signed({cen_rdata_reg[VAL_BITS-1], cen_rdata_reg});
        sq_reg      <= $unsigned(sq_full);
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            acc_we_reg   <= 1'b0;
            touched_reg  <= '0;
        end else begin
            acc_we_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Pending read: the registered memory data goes to the output register
            if (rd_pend_reg) begin
                rd_pend_reg  <= 1'b0;
                m_tvalid_reg <= 1'b1;
                if (rd_lbl_reg) begin
                    m_tdata_reg <= {76'd0, lbl_rdata_reg};
                end else if (rd_ok_reg) begin
                    m_tdata_reg <= {60'd0, cen_rdata_reg, 4'd0};
                end else begin
                    m_tdata_reg <= '0;
                end
            end

            // Final stage of the distance pipeline
            if (p3_vld_reg) begin
                if (p3_last_reg) begin
                    acc_reg <= '0;
                    if (p3_inr_reg) begin
                        inertia_reg <= inertia_reg + INR_BITS'(dist_sum);
                    end else if ((p3_j_reg == '0) || (dist_sum < bestd_reg)) begin
                        bestd_reg <= dist_sum;
                        best_reg  <= p3_j_reg;
                    end
                end else begin
                    acc_reg <= dist_sum;
                end
            end

            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PT_BITS'(MAX_POINTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (in_op == OP_RD_LBL || in_op == OP_RD_CEN) begin
                            rd_pend_reg <= 1'b1;
                            rd_lbl_reg  <= (in_op == OP_RD_LBL);
                            rd_ok_reg   <= (in_item < PT_BITS'(MAX_CLUSTERS));
                        end else if (in_op == OP_RUN) begin
                            if (n_eff == 11'd0) begin
                                m_tvalid_reg <= 1'b1;
                                m_tdata_reg  <= '0;
                                inertia_reg  <= '0;
                            end else begin
                                nm1_reg     <= PT_BITS'(n_eff - 11'd1);
                                km1_reg     <= CL_BITS'(k_eff - 5'd1);
                                dm1_reg     <= DIM_BITS'(dims_eff - 4'd1);
                                limit_reg   <= lim_eff;
                                iters_reg   <= '0;
                                first_reg   <= 1'b1;
                                changed_reg <= 1'b0;
                                inertia_reg <= '0;
                                acc_reg     <= '0;
                                pi_reg      <= '0;
                                cj_reg      <= '0;
                                cd_reg      <= '0;
                                touched_reg <= '0;
                                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                                    cnt_reg[c] <= '0;
                                end
                                state_reg <= S_ASN;
                            end
                        end
                    end
                end
                // Stream point-to-centroid coordinate pairs
                S_ASN: begin
                    if (cd_reg == dm1_reg) begin
                        cd_reg <= '0;
                        if (cj_reg == km1_reg) begin
                            state_reg <= S_ASN_DRN;
                        end else begin
                            cj_reg <= cj_reg + 1'b1;
                        end
                    end else begin
                        cd_reg <= cd_reg + 1'b1;
                    end
                end
                S_ASN_DRN: begin
                    if (!pipe_busy) begin
                        state_reg <= S_ASN_LBL;
                    end
                end
                S_ASN_LBL: begin
                    if (best_reg != old_lbl) begin
                        changed_reg <= 1'b1;
                    end
                    cd_reg    <= '0;
                    state_reg <= S_ACC;
                end
                // Add the point into its cluster's sums
                S_ACC: begin
                    acc_we_reg    <= 1'b1;
                    acc_waddr_reg <= {best_reg, cd_reg};
                    if (cd_reg == dm1_reg) begin
                        state_reg <= S_ACC_FIN;
                    end else begin
                        cd_reg <= cd_reg + 1'b1;
                    end
                end
                S_ACC_FIN: begin
                    touched_reg[best_reg] <= 1'b1;
                    cnt_reg[best_reg]     <= cnt_reg[best_reg] + 1'b1;
                    cd_reg                <= '0;
                    cj_reg                <= '0;
                    if (pi_reg == nm1_reg) begin
                        state_reg <= S_UPD;
                    end else begin
                        pi_reg    <= pi_reg + 1'b1;
                        state_reg <= S_ASN;
                    end
                end
                // Recompute centroids of non-empty clusters
                S_UPD: begin
                    cd_reg <= '0;
                    if (cnt_reg[cj_reg] != '0) begin
                        state_reg <= S_UPD_RD;
                    end else if (cj_reg == km1_reg) begin
                        state_reg <= S_ITER;
                    end else begin
                        cj_reg <= cj_reg + 1'b1;
                    end
                end
                S_UPD_RD: begin
                    state_reg <= S_UPD_DIV;
                end
                S_UPD_DIV: begin
                    state_reg <= S_UPD_WAIT;
                end
                S_UPD_WAIT: begin
                    if (div_done) begin
                        if (cd_reg == dm1_reg) begin
                            cd_reg <= '0;
                            if (cj_reg == km1_reg) begin
                                state_reg <= S_ITER;
                            end else begin
                                cj_reg    <= cj_reg + 1'b1;
                                state_reg <= S_UPD;
                            end
                        end else begin
                            cd_reg    <= cd_reg + 1'b1;
                            state_reg <= S_UPD_RD;
                        end
                    end
                end
                S_ITER: begin
                    iters_reg <= iters_next;
                    pi_reg    <= '0;
                    cj_reg    <= '0;
                    cd_reg    <= '0;
                    if (!changed_reg || (iters_next == limit_reg)) begin
                        conv_reg  <= !changed_reg;
                        state_reg <= S_INR_LBL;
                    end else begin
                        first_reg   <= 1'b0;
                        changed_reg <= 1'b0;
                        touched_reg <= '0;
                        for (int c = 0; c < MAX_CLUSTERS; c++) begin
                            cnt_reg[c] <= '0;
                        end
                        state_reg <= S_ASN;
                    end
                end
                // Inertia pass over final labels
                S_INR_LBL: begin
                    state_reg <= S_INR_GET;
                end
                S_INR_GET: begin
                    cj_reg    <= lbl_rdata_reg;
                    cd_reg    <= '0;
                    state_reg <= S_INR;
                end
                S_INR: begin
                    if (cd_reg == dm1_reg) begin
                        state_reg <= S_INR_DRN;
                    end else begin
                        cd_reg <= cd_reg + 1'b1;
                    end
                end
                S_INR_DRN: begin
                    if (!pipe_busy) begin
                        if (pi_reg == nm1_reg) begin
                            state_reg <= S_DONE;
                        end else begin
                            pi_reg    <= pi_reg + 1'b1;
                            state_reg <= S_INR_LBL;
                        end
                    end
                end
                S_DONE: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= {3'd0, conv_reg, iters_reg, inertia_reg, 20'd0};
                    state_reg    <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on sequencer and datapath interplay
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_UPD_WAIT)
        else $error("divider finished outside the update wait");

    a_acc_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_we_reg |-> (state_reg == S_ACC || state_reg == S_ACC_FIN))
        else $error("sum write outside the accumulate phase");

    a_best_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ASN_LBL |-> best_reg <= km1_reg)
        else $error("assigned cluster beyond the cluster count");

    a_pipe_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(p1_vld_reg) |-> ($past(state_reg) == S_ASN || $past(state_reg) == S_INR))
        else $error("distance pipeline started outside a distance phase");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for kmeans_cluster_engine_top: drives load, run and read requests
// with random idling and checks every result against an in-bench predictor.
// Depends on kce_pkg and the engine RTL only.
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import kce_pkg::*;

    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam longint INR_MAX     = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        conv;
        logic [7:0]  iters;
        logic [47:0] inertia;
        logic [15:0] cval;
        logic [3:0]  label;
    } kce_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // item_index[9:0], coord_index[12:10], coord_value[28:13]
    logic [2:0]  s_tuser = '0;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // label[3:0], centroid_value[19:4], inertia[67:20],
                                 // iterations_used[75:68], converged[76]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [10:0] cfg_wdata = '0;

    kmeans_cluster_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    longint      pt_mem [PT_DEPTH];
    longint      cen_mem [CEN_DEPTH];
    bit          pt_wr [PT_DEPTH];
    bit          cen_wr [CEN_DEPTH];
    logic [3:0]  lbl_mem [MAX_POINTS];
    logic [4:0]  cfg_k = 5'd4;
    logic [7:0]  cfg_iter = 8'd100;
    logic [3:0]  cfg_dims = 4'd2;
    logic [10:0] cfg_pts = 11'd0;

    kce_result_t expected_q[$];
    int          err_count = 0;
    int          req_count = 0;
    int          run_count = 0;
    int          conv_count = 0;
    int          result_count = 0;
    longint      cycle_count = 0;
    bit          tx_fast = 0;
    bit          rx_fast = 0;
    int          rx_hold = 0;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        err_count++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Effective configuration as the engine applies it
    function automatic int eff_points();
        return (cfg_pts > MAX_POINTS) ? MAX_POINTS : int'(cfg_pts);
    endfunction
    function automatic int eff_clusters();
        int k;
        k = (cfg_k == 0) ? 1 : ((cfg_k > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cfg_k));
        return (k > eff_points()) ? eff_points() : k;
    endfunction
    function automatic int eff_dims();
        return (cfg_dims == 0) ? 1 : ((cfg_dims > MAX_DIMS) ? MAX_DIMS : int'(cfg_dims));
    endfunction

    function automatic longint sq_distance(int p, int c, int dims);
        longint acc, diff;
        acc = 0;
        for (int d = 0; d < dims; d++) begin
            diff = pt_mem[p*MAX_DIMS+d] - cen_mem[c*MAX_DIMS+d];
            acc += diff * diff;
        end
        return acc;
    endfunction

    // Lloyd iterations over the predictor stores
    function automatic kce_result_t cluster_run();
        kce_result_t r;
        int n, k, dims, limit, iters, best;
        bit done;
        longint cand_d, best_d, inr;
        longint sums [CEN_DEPTH];
        int counts [MAX_CLUSTERS];
        r = '0;
        n = eff_points();
        if (n == 0) return r;
        k = eff_clusters();
        dims = eff_dims();
        limit = (cfg_iter == 0) ? 1 : int'(cfg_iter);
        iters = 0;
        done = 0;
        for (int i = 0; i < n; i++) lbl_mem[i] = '0;
        while (iters < limit && !done) begin
            done = 1;
            for (int i = 0; i < n; i++) begin
                best = 0;
                best_d = 0;
                for (int j = 0; j < k; j++) begin
                    cand_d = sq_distance(i, j, dims);
                    if (j == 0 || cand_d < best_d) begin
                        best_d = cand_d;
                        best = j;
                    end
                end
                if (lbl_mem[i] != best) begin
                    done = 0;
                    lbl_mem[i] = best[3:0];
                end
            end
            for (int e = 0; e < CEN_DEPTH; e++) sums[e] = 0;
            for (int j = 0; j < MAX_CLUSTERS; j++) counts[j] = 0;
            for (int i = 0; i < n; i++) begin
                counts[lbl_mem[i]]++;
                for (int d = 0; d < dims; d++)
                    sums[lbl_mem[i]*MAX_DIMS+d] += pt_mem[i*MAX_DIMS+d];
            end
            // empty clusters keep their centroid; division truncates toward zero
            for (int j = 0; j < k; j++)
                if (counts[j] != 0)
                    for (int d = 0; d < dims; d++)
                        cen_mem[j*MAX_DIMS+d] = sums[j*MAX_DIMS+d] / longint'(counts[j]);
            iters++;
        end
        inr = 0;
        for (int i = 0; i < n; i++) begin
            inr += sq_distance(i, lbl_mem[i], dims);
            if (inr > INR_MAX) inr = INR_MAX;
        end
        r.inertia = inr[47:0];
        r.iters = iters[7:0];
        r.conv = done;
        return r;
    endfunction

    // Apply one accepted request to the predictor
    task automatic predict(input logic [2:0] op, input int item, input int coord,
                           input logic signed [15:0] val);
        kce_result_t r;
        r = '0;
        case (op)
            OP_LOAD_PT: begin
                pt_mem[item*MAX_DIMS+coord] = val;
                pt_wr[item*MAX_DIMS+coord] = 1;
            end
            OP_LOAD_CEN: begin
                if (item < MAX_CLUSTERS) begin
                    cen_mem[item*MAX_DIMS+coord] = val;
                    cen_wr[item*MAX_DIMS+coord] = 1;
                end
            end
            OP_RUN: begin
                r = cluster_run();
                run_count++;
                if (r.conv) conv_count++;
                expected_q.push_back(r);
            end
            OP_RD_LBL: begin
                r.label = lbl_mem[item];
                expected_q.push_back(r);
            end
            OP_RD_CEN: begin
                if (item < MAX_CLUSTERS) r.cval = cen_mem[item*MAX_DIMS+coord][15:0];
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Send one request and wait until it is taken
    task automatic send(input logic [2:0] op, input int item, input int coord = 0,
                        input logic [15:0] val = '0);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, val, coord[2:0], item[9:0]};
        do @(posedge aclk); while (!s_tready);
        predict(op, item, coord, val);
        if (op <= OP_RD_CEN) req_count++;
    endtask

    // Wait until every expected result has come, then let the engine settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [10:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CLUSTERS: cfg_k = val[4:0];
            CFG_ITERS:    cfg_iter = val[7:0];
            CFG_DIMS:     cfg_dims = val[3:0];
            default:      cfg_pts = val;
        endcase
    endtask

    task automatic configure(input int k, input int iters, input int dims, input int pts);
        cfg_write(CFG_CLUSTERS, k[10:0]);
        cfg_write(CFG_ITERS, iters[10:0]);
        cfg_write(CFG_DIMS, dims[10:0]);
        cfg_write(CFG_POINTS, pts[10:0]);
    endtask

    // Random coordinate: sometimes full range, mostly grouped around a few spots
    function automatic logic [15:0] rand_coord();
        int spot;
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hFFFF));
        spot = $urandom_range(0, 3) * 12000 - 18000;
        return 16'(spot + $urandom_range(0, 2000) - 1000);
    endfunction

    // Load whatever the next run uses and was never written
    task automatic fill_missing();
        for (int i = 0; i < eff_points(); i++)
            for (int d = 0; d < eff_dims(); d++)
                if (!pt_wr[i*MAX_DIMS+d]) send(OP_LOAD_PT, i, d, rand_coord());
        for (int j = 0; j < eff_clusters(); j++)
            for (int d = 0; d < eff_dims(); d++)
                if (!cen_wr[j*MAX_DIMS+d]) send(OP_LOAD_CEN, j, d, rand_coord());
    endtask

    task automatic read_back();
        for (int i = 0; i < eff_points(); i++) send(OP_RD_LBL, i);
        for (int j = 0; j < MAX_CLUSTERS; j++)
            for (int d = 0; d < eff_dims(); d++)
                if (cen_wr[j*MAX_DIMS+d]) send(OP_RD_CEN, j, d);
    endtask

    // Result receiver with random stalls and long hold-offs on request
    initial begin : receiver
        int wait_n;
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                @(posedge aclk);
                rx_hold--;
            end else begin
                wait_n = rx_fast ? 0 : $urandom_range(0, 14);
                if (wait_n > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        kce_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                report("unexpected result", m_tdata[63:0], 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[3:0] !== want.label) report("label", m_tdata[3:0], want.label);
                if (m_tdata[19:4] !== want.cval)
                    report("centroid_value", m_tdata[19:4], want.cval);
                if (m_tdata[67:20] !== want.inertia)
                    report("inertia", m_tdata[67:20], want.inertia);
                if (m_tdata[75:68] !== want.iters)
                    report("iterations_used", m_tdata[75:68], want.iters);
                if (m_tdata[76] !== want.conv) report("converged", m_tdata[76], want.conv);
            end
        end
    end

    // Defaults after reset, empty run, ignored and out-of-range requests
    task automatic test_reset_state();
        send(OP_RUN, 0);
        send(OP_RD_LBL, 0);
        send(OP_RD_LBL, 1023);
        send(OP_RD_CEN, 16, 7);
        send(OP_RD_CEN, 1023, 0);
        send(3'd5, 1023, 7, 16'hFFFF);
        send(3'd6, 0);
        send(3'd7, 512, 3, 16'h1234);
        send(OP_LOAD_CEN, 20, 1, 16'h7FFF);
        send(OP_RD_CEN, 20, 1);
    endtask

    // Small hand-made data set: extreme values and a distance tie
    task automatic test_directed_run();
        configure(3, 10, 2, 6);
        send(OP_LOAD_PT, 0, 0, 16'h8000); send(OP_LOAD_PT, 0, 1, 16'h8000);
        send(OP_LOAD_PT, 1, 0, 16'h7FFF); send(OP_LOAD_PT, 1, 1, 16'h7FFF);
        send(OP_LOAD_PT, 2, 0, 16'h8000); send(OP_LOAD_PT, 2, 1, 16'h7FFF);
        send(OP_LOAD_PT, 3, 0, 16'd0);    send(OP_LOAD_PT, 3, 1, 16'd0);
        send(OP_LOAD_PT, 4, 0, -16'sd3);  send(OP_LOAD_PT, 4, 1, 16'd1);
        send(OP_LOAD_PT, 5, 0, 16'd0);    send(OP_LOAD_PT, 5, 1, 16'd2);
        // clusters 1 and 2 start on the same spot: the lower index must win
        for (int j = 0; j < 3; j++)
            for (int d = 0; d < 2; d++)
                send(OP_LOAD_CEN, j, d, (j == 0) ? 16'h8000 : 16'd5);
        send(OP_RUN, 0);
        read_back();
    endtask

    // Register extremes, including the largest point set
    task automatic test_config_extremes();
        configure(0, 0, 0, 1);
        fill_missing();
        send(OP_RUN, 0);
        read_back();
        configure(31, 255, 15, 9);
        fill_missing();
        send(OP_RUN, 0);
        read_back();
        configure(2, 3, 1, 2047);
        fill_missing();
        send(OP_RUN, 0);
        send(OP_RD_LBL, 1023);
        send(OP_RD_LBL, 0);
        send(OP_RD_CEN, 1, 0);
        configure(16, 2, 8, 1024);
        drain();
        configure(1, 1, 8, 4);
        fill_missing();
        send(OP_RUN, 0);
        read_back();
    endtask

    // Receiver holds off while back-to-back reads stall the sender, then all results are drained
    task automatic test_backpressure();
        drain();
        tx_fast = 1;
        rx_hold = 400;
        for (int i = 0; i < 40; i++) send(OP_RD_LBL, $urandom_range(0, 1023));
        send(OP_RUN, 0);
        tx_fast = 0;
        drain();
    endtask

    // Random scenarios: fresh data, a run, read-back, plus noise
    task automatic test_random(input int target);
        int n, k, dims, iters;
        while (req_count < target) begin
            tx_fast = ($urandom_range(0, 4) == 0);
            rx_fast = ($urandom_range(0, 4) == 0);
            n = $urandom_range(1, 14);
            dims = $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0) begin
                iters = $urandom_range(9, 255);
                k = $urandom_range(0, 4);
            end else begin
                iters = $urandom_range(0, 8);
                k = $urandom_range(0, 17);
            end
            configure(k, iters, dims, n);
            for (int i = 0; i < n; i++)
                for (int d = 0; d < MAX_DIMS; d++)
                    if ($urandom_range(0, 2) != 0 || d < eff_dims())
                        send(OP_LOAD_PT, i, d, rand_coord());
            for (int j = 0; j < MAX_CLUSTERS; j++)
                if (j < eff_clusters() || $urandom_range(0, 3) == 0)
                    for (int d = 0; d < eff_dims(); d++)
                        send(OP_LOAD_CEN, j, d, rand_coord());
            // noise: ignored codes, stray loads, wide reads
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 3))
                    0: send(3'($urandom_range(5, 7)), $urandom_range(0, 1023),
                            $urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
                    1: send(OP_LOAD_PT, $urandom_range(16, 1023), $urandom_range(0, 7),
                            $urandom_range(0, 16'hFFFF));
                    2: send(OP_LOAD_CEN, $urandom_range(16, 1023), $urandom_range(0, 7),
                            $urandom_range(0, 16'hFFFF));
                    default: send(OP_RD_LBL, $urandom_range(0, 1023));
                endcase
            end
            fill_missing();
            send(OP_RUN, 0);
            read_back();
        end
        tx_fast = 0;
        rx_fast = 0;
    endtask

    initial begin : stimulus
        for (int e = 0; e < PT_DEPTH; e++) begin pt_mem[e] = 0; pt_wr[e] = 0; end
        for (int e = 0; e < CEN_DEPTH; e++) begin cen_mem[e] = 0; cen_wr[e] = 0; end
        for (int i = 0; i < MAX_POINTS; i++) lbl_mem[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_directed_run();
        test_config_extremes();
        test_backpressure();
        test_random(2000);

        drain();
        repeat (200) @(posedge aclk);
        $display("Covered %0d requests, %0d runs (%0d converged), %0d results checked.",
                 req_count, run_count, conv_count, result_count);
        $display("Register extremes, ties, ignored codes and long result stalls included.");
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, expected_q.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/kce_pkg.sv
hdl/kce_div.sv
hdl/kmeans_cluster_engine_top.sv
verif/tb.sv
